// ===== hw/rtl/word_frequency_counter_macros.svh =====
// Assertion macros used by the word frequency counter top level.
`ifndef WORD_FREQUENCY_COUNTER_MACROS_SVH
`define WORD_FREQUENCY_COUNTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word frequency counter check failed");
`define WFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word frequency counter check failed");
`else
`define WFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/wfc_pkg.sv =====
// Shared constants, types and character helpers of the word frequency counter.
package wfc_pkg;

    localparam int TABLE_SLOTS_DEF = 32;
    localparam int WORD_CHARS_DEF  = 31;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CHAR_W     = 8;
    localparam int SLOT_W     = 5;
    localparam int POS_W      = 5;
    localparam int TOTAL_W    = 16;
    localparam int DISTINCT_W = 6;
    localparam int LENGTH_W   = 5;

    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_END  = 2'd1,
        REQ_READ = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic                  word_done;
        logic [SLOT_W-1:0]     slot_hit;
        logic [TOTAL_W-1:0]    word_total;
        logic                  is_new;
        logic                  dropped;
        logic                  text_done;
        logic [DISTINCT_W-1:0] distinct;
        logic [CHAR_W-1:0]     read_char;
        logic [LENGTH_W-1:0]   read_length;
        logic [TOTAL_W-1:0]    read_total;
    } result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_DIG_0 && c <= CH_DIG_9);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? 8'(c + CASE_GAP) : c;
    endfunction

endpackage

// ===== hw/rtl/wfc_req_if.sv =====
// Request channel: text bytes, end of text and read requests.
interface wfc_req_if import wfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] ch;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;

    modport source (output valid, req_type, ch, slot, pos, input ready);
    modport sink (input valid, req_type, ch, slot, pos, output ready);
endinterface

// ===== hw/rtl/wfc_res_if.sv =====
// Result channel: word updates, end-of-text reports and read data.
interface wfc_res_if import wfc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  word_done;
    logic [SLOT_W-1:0]     slot_hit;
    logic [TOTAL_W-1:0]    word_total;
    logic                  is_new;
    logic                  dropped;
    logic                  text_done;
    logic [DISTINCT_W-1:0] distinct;
    logic [CHAR_W-1:0]     read_char;
    logic [LENGTH_W-1:0]   read_length;
    logic [TOTAL_W-1:0]    read_total;

    modport source (output valid, word_done, slot_hit, word_total, is_new, dropped,
                    text_done, distinct, read_char, read_length, read_total,
                    input ready);
    modport sink (input valid, word_done, slot_hit, word_total, is_new, dropped,
                  text_done, distinct, read_char, read_length, read_total,
                  output ready);
endinterface

// ===== hw/rtl/word_frequency_counter.sv =====
// Word frequency counter top level.
// A byte that finishes no word stays in idle; a read fetches slot data, then posts; a
// dropped word or bare end posts directly. A finished word checks each stored slot's
// length, compares characters in slots of equal length, then raises a hit or copies a
// new word, and posts when the single result register is free.
// Reset clears the control state and leaves the text closed; the table is not cleared.
`include "word_frequency_counter_macros.svh"
module word_frequency_counter import wfc_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int WORD_CHARS  = WORD_CHARS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    wfc_req_if.sink   req,
    wfc_res_if.source res
);
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int DW = $clog2(TABLE_SLOTS+1);
    localparam int TW = $clog2(WORD_CHARS);
    localparam int LW = $clog2(WORD_CHARS+1);
    localparam int AW = $clog2(TABLE_SLOTS*WORD_CHARS);
    localparam int EW = LW + COUNT_BITS;
    localparam logic [LW-1:0] WC_L = LW'(WORD_CHARS);
    localparam logic [DW-1:0] SLOTS_D = DW'(TABLE_SLOTS);
    localparam logic [AW-1:0] WC_A = AW'(WORD_CHARS);
    localparam logic [COUNT_BITS-1:0] CAP = '1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOOK = 9'b000000010,
        S_LCHK = 9'b000000100,
        S_CRD  = 9'b000001000,
        S_CCHK = 9'b000010000,
        S_HIT  = 9'b000100000,
        S_COPY = 9'b001000000,
        S_RRD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [DW-1:0]   distinct_reg, distinct_next;
    logic [LW-1:0]   tl_reg, tl_next;
    logic [7:0]      prev_reg, prev_next;
    logic            apos_reg, apos_next;
    logic            closed_reg, closed_next;
    logic [LW-1:0]   fin_len_reg, fin_len_next;
    logic            defer_reg, defer_next;
    logic [7:0]      defer_ch_reg, defer_ch_next;
    logic [DW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [LW-1:0]   k_reg, k_next;
    logic            rd_ok_reg, rd_ok_next;
    logic [POS_W-1:0] rd_pos_reg, rd_pos_next;
    result_t         pend_reg, pend_next;
    result_t         out_reg, out_next;
    logic            out_v_reg, out_v_next;

    logic [7:0]      tok_reg [WORD_CHARS];
    logic            tok_we_a, tok_we_b;
    logic [TW-1:0]   tok_idx_a, tok_idx_b;
    logic [7:0]      tok_dat_b;
    logic [7:0]      tok_k;

    logic            txt_we, ent_we;
    logic [AW-1:0]   txt_waddr, txt_raddr;
    logic [7:0]      txt_wdata, txt_rdata;
    logic [IW-1:0]   ent_waddr, ent_raddr;
    logic [EW-1:0]   ent_wdata, ent_rdata;
    logic [LW-1:0]   ent_len;
    logic [COUNT_BITS-1:0] ent_tally;

    wfc_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .WORD_CHARS  (WORD_CHARS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_table (
        .clk       (clk),
        .txt_we    (txt_we),
        .txt_waddr (txt_waddr),
        .txt_wdata (txt_wdata),
        .txt_raddr (txt_raddr),
        .txt_rdata (txt_rdata),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata)
    );

    assign ent_len   = ent_rdata[EW-1:COUNT_BITS];
    assign ent_tally = ent_rdata[COUNT_BITS-1:0];
    assign tok_k     = tok_reg[k_reg[TW-1:0]];

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_v_reg;
    assign res.word_done   = out_reg.word_done;
    assign res.slot_hit    = out_reg.slot_hit;
    assign res.word_total  = out_reg.word_total;
    assign res.is_new      = out_reg.is_new;
    assign res.dropped     = out_reg.dropped;
    assign res.text_done   = out_reg.text_done;
    assign res.distinct    = out_reg.distinct;
    assign res.read_char   = out_reg.read_char;
    assign res.read_length = out_reg.read_length;
    assign res.read_total  = out_reg.read_total;

    always_comb
    begin
        logic [LW-1:0] tl_e;
        logic [7:0]    prev_e;
        logic          apos_e;
        logic [DW-1:0] dist_e;
        logic          an;
        logic          apos_app;
        logic [LW-1:0] tl1;
        logic [LW-1:0] tl2;
        logic          fin;
        logic [LW-1:0] fin_l;
        logic          rd_ok;
        logic [COUNT_BITS-1:0] new_tally;
        logic          next_slot;

        state_next    = state_reg;
        distinct_next = distinct_reg;
        tl_next       = tl_reg;
        prev_next     = prev_reg;
        apos_next     = apos_reg;
        closed_next   = closed_reg;
        fin_len_next  = fin_len_reg;
        defer_next    = defer_reg;
        defer_ch_next = defer_ch_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        rd_ok_next    = rd_ok_reg;
        rd_pos_next   = rd_pos_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg;

        tok_we_a  = 1'b0;
        tok_we_b  = 1'b0;
        tok_idx_a = '0;
        tok_idx_b = '0;
        tok_dat_b = '0;

        txt_we    = 1'b0;
        txt_waddr = AW'(base_reg + AW'(k_reg));
        txt_wdata = tok_k;
        txt_raddr = AW'(base_reg + AW'(k_reg));
        ent_we    = 1'b0;
        ent_waddr = idx_reg[IW-1:0];
        ent_wdata = '0;
        ent_raddr = idx_reg[IW-1:0];

        tl_e      = closed_reg ? '0 : tl_reg;
        prev_e    = closed_reg ? '0 : prev_reg;
        apos_e    = closed_reg ? 1'b0 : apos_reg;
        dist_e    = closed_reg ? '0 : distinct_reg;
        an        = is_alnum(req.ch);
        apos_app  = apos_e & an;
        tl1       = LW'(tl_e + LW'(apos_app));
        tl2       = LW'(tl1 + LW'(1));
        fin       = 1'b0;
        fin_l     = tl_e;
        rd_ok     = 32'(req.slot) < 32'(distinct_reg);
        new_tally = (ent_tally == CAP) ? ent_tally : COUNT_BITS'(ent_tally + 1'b1);
        next_slot = 1'b0;

        if (out_v_reg && res.ready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pend_next = '0;
                    idx_next  = '0;
                    base_next = '0;
                    k_next    = '0;
                    case (req.req_type)
                        REQ_BYTE:
                        begin
                            prev_next     = req.ch;
                            closed_next   = 1'b0;
                            distinct_next = dist_e;
                            apos_next     = 1'b0;
                            tl_next       = tl_e;
                            if (apos_app)
                            begin
                                tok_we_a  = 1'b1;
                                tok_idx_a = tl_e[TW-1:0];
                            end
                            // An apostrophe that fills the word finishes it; this
                            // byte then waits to start the next word.
                            if (apos_app && tl1 == WC_L)
                            begin
                                fin           = 1'b1;
                                fin_l         = WC_L;
                                defer_next    = 1'b1;
                                defer_ch_next = fold(req.ch);
                                tl_next       = '0;
                            end
                            else if (an)
                            begin
                                tok_we_b  = 1'b1;
                                tok_idx_b = tl1[TW-1:0];
                                tok_dat_b = fold(req.ch);
                                if (tl2 == WC_L)
                                begin
                                    fin     = 1'b1;
                                    fin_l   = WC_L;
                                    tl_next = '0;
                                end
                                else
                                begin
                                    tl_next = tl2;
                                end
                            end
                            else if (apos_e)
                            begin
                                fin     = (tl_e != '0);
                                tl_next = '0;
                            end
                            else if (req.ch == CH_APOS && is_alnum(prev_e))
                            begin
                                apos_next = 1'b1;
                            end
                            else
                            begin
                                fin     = (tl_e != '0);
                                tl_next = '0;
                            end
                        end
                        REQ_END:
                        begin
                            apos_next           = 1'b0;
                            fin                 = (tl_e != '0);
                            tl_next             = '0;
                            prev_next           = '0;
                            closed_next         = 1'b1;
                            distinct_next       = dist_e;
                            pend_next.text_done = 1'b1;
                            state_next          = S_OUT;
                        end
                        REQ_READ:
                        begin
                            rd_ok_next  = rd_ok;
                            rd_pos_next = req.pos;
                            if (rd_ok)
                            begin
                                ent_raddr = IW'(req.slot);
                                if (32'(req.pos) < WORD_CHARS)
                                begin
                                    txt_raddr = AW'(32'(req.slot) * WORD_CHARS + 32'(req.pos));
                                end
                            end
                            state_next = S_RRD;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (fin)
                    begin
                        fin_len_next        = fin_l;
                        pend_next.word_done = 1'b1;
                        if (dist_e == SLOTS_D)
                        begin
                            pend_next.dropped = 1'b1;
                            state_next        = S_OUT;
                        end
                        else if (dist_e == '0)
                        begin
                            state_next = S_COPY;
                        end
                        else
                        begin
                            state_next = S_LOOK;
                        end
                    end
                end
            end
            S_LOOK:
            begin
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                if (ent_len == fin_len_reg)
                begin
                    k_next     = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    next_slot = 1'b1;
                end
            end
            S_CRD:
            begin
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (txt_rdata == tok_k)
                begin
                    if (LW'(k_reg + LW'(1)) == fin_len_reg)
                    begin
                        state_next = S_HIT;
                    end
                    else
                    begin
                        k_next     = LW'(k_reg + LW'(1));
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    next_slot = 1'b1;
                end
            end
            S_HIT:
            begin
                ent_we               = 1'b1;
                ent_wdata            = {ent_len, new_tally};
                pend_next.slot_hit   = SLOT_W'(idx_reg);
                pend_next.word_total = TOTAL_W'(new_tally);
                state_next           = S_OUT;
            end
            S_COPY:
            begin
                txt_we = 1'b1;
                k_next = LW'(k_reg + LW'(1));
                if (LW'(k_reg + LW'(1)) == fin_len_reg)
                begin
                    ent_we               = 1'b1;
                    ent_wdata            = {fin_len_reg, COUNT_BITS'(1)};
                    distinct_next        = DW'(distinct_reg + DW'(1));
                    pend_next.slot_hit   = SLOT_W'(idx_reg);
                    pend_next.word_total = TOTAL_W'(1);
                    pend_next.is_new     = 1'b1;
                    state_next           = S_OUT;
                end
            end
            S_RRD:
            begin
                if (rd_ok_reg)
                begin
                    pend_next.read_length = LENGTH_W'(ent_len);
                    pend_next.read_total  = TOTAL_W'(ent_tally);
                    if (32'(rd_pos_reg) < 32'(ent_len) && 32'(rd_pos_reg) < WORD_CHARS)
                    begin
                        pend_next.read_char = txt_rdata;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_v_reg || res.ready)
                begin
                    out_next          = pend_reg;
                    out_next.distinct = DISTINCT_W'(distinct_reg);
                    out_v_next        = 1'b1;
                    state_next        = S_IDLE;
                    if (defer_reg)
                    begin
                        tok_we_b   = 1'b1;
                        tok_idx_b  = '0;
                        tok_dat_b  = defer_ch_reg;
                        tl_next    = LW'(1);
                        defer_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // No stored word matched in this slot: try the next one, or take a new
        // slot once every stored word has been checked.
        if (next_slot)
        begin
            idx_next  = DW'(idx_reg + DW'(1));
            base_next = AW'(base_reg + WC_A);
            k_next    = '0;
            if (DW'(idx_reg + DW'(1)) == distinct_reg)
            begin
                state_next = S_COPY;
            end
            else
            begin
                state_next = S_LOOK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            distinct_reg <= '0;
            tl_reg       <= '0;
            prev_reg     <= '0;
            apos_reg     <= 1'b0;
            closed_reg   <= 1'b1;
            defer_reg    <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
            tl_reg       <= tl_next;
            prev_reg     <= prev_next;
            apos_reg     <= apos_next;
            closed_reg   <= closed_next;
            defer_reg    <= defer_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_len_reg  <= fin_len_next;
        defer_ch_reg <= defer_ch_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        k_reg        <= k_next;
        rd_ok_reg    <= rd_ok_next;
        rd_pos_reg   <= rd_pos_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        for (int j = 0; j < WORD_CHARS; j++)
        begin
            if (tok_we_a && tok_idx_a == TW'(j))
            begin
                tok_reg[j] <= CH_APOS;
            end
            if (tok_we_b && tok_idx_b == TW'(j))
            begin
                tok_reg[j] <= tok_dat_b;
            end
        end
    end

    `WFC_ASSERT_NEXT(a_out_hold, clk, rst_n, state_reg == S_OUT && out_v_reg && !res.ready, state_reg == S_OUT)
    `WFC_ASSERT_IMPLY(a_tok_bound, clk, rst_n, state_reg == S_IDLE, tl_reg < WC_L)
    `WFC_ASSERT_NEXT(a_end_result, clk, rst_n, req.valid && req.ready && req.req_type == REQ_END, state_reg != S_IDLE)
    `WFC_ASSERT_IMPLY(a_dist_bound, clk, rst_n, state_reg != S_IDLE, distinct_reg <= SLOTS_D)
endmodule

// ===== hw/rtl/wfc_table.sv =====
// Word table storage: character memory and per-slot length and count memory.
module wfc_table import wfc_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int WORD_CHARS  = WORD_CHARS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          txt_we,
    input  logic [$clog2(TABLE_SLOTS*WORD_CHARS)-1:0]     txt_waddr,
    input  logic [CHAR_W-1:0]                             txt_wdata,
    input  logic [$clog2(TABLE_SLOTS*WORD_CHARS)-1:0]     txt_raddr,
    output logic [CHAR_W-1:0]                             txt_rdata,
    input  logic                                          ent_we,
    input  logic [$clog2(TABLE_SLOTS)-1:0]                ent_waddr,
    input  logic [$clog2(WORD_CHARS+1)+COUNT_BITS-1:0]    ent_wdata,
    input  logic [$clog2(TABLE_SLOTS)-1:0]                ent_raddr,
    output logic [$clog2(WORD_CHARS+1)+COUNT_BITS-1:0]    ent_rdata
);
    localparam int DEPTH = TABLE_SLOTS * WORD_CHARS;
    localparam int EW    = $clog2(WORD_CHARS+1) + COUNT_BITS;

    logic [CHAR_W-1:0] txt_mem [DEPTH];
    logic [EW-1:0]     ent_mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[txt_waddr] <= txt_wdata;
        end
        txt_rdata <= txt_mem[txt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[ent_raddr];
    end
endmodule

// ===== tb/sv/word_frequency_counter_checker.sv =====
// Checker: predicts word frequency counter results and compares them on the result channel.
module word_frequency_counter_checker import wfc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    wfc_req_if   req,
    wfc_res_if   res,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TABLE_SLOTS_DEF;
    localparam int CHARS = WORD_CHARS_DEF;

    logic [CHAR_W-1:0]   tbl_text [SLOTS][CHARS];
    logic [LENGTH_W-1:0] tbl_len [SLOTS];
    logic [TOTAL_W-1:0]  tbl_count [SLOTS];
    int                  n_words;
    logic [CHAR_W-1:0]   tok [CHARS];
    int                  tok_len;
    logic [CHAR_W-1:0]   last_byte;
    bit                  apos_wait;
    bit                  closed;
    result_t             expected_q[$];

    function automatic bit alnum(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    task automatic open_text();
        n_words   = 0;
        tok_len   = 0;
        last_byte = 8'd0;
        apos_wait = 0;
        closed    = 0;
    endtask

    // Looks the pending token up in the word table and updates it.
    task automatic close_token(inout result_t r, output bit got);
        int i;
        int j;
        bit same;
        got = 0;
        if (tok_len == 0)
            return;
        got = 1;
        r.word_done = 1'b1;
        if (n_words >= SLOTS)
            r.dropped = 1'b1;
        else
        begin
            for (i = 0; i < n_words; i++)
            begin
                same = (tbl_len[i] == tok_len);
                for (j = 0; j < tok_len; j++)
                    if (same && tbl_text[i][j] != tok[j])
                        same = 0;
                if (same)
                    break;
            end
            if (i < n_words)
            begin
                if (tbl_count[i] != '1)
                    tbl_count[i]++;
            end
            else
            begin
                for (j = 0; j < tok_len; j++)
                    tbl_text[i][j] = tok[j];
                tbl_len[i]   = LENGTH_W'(tok_len);
                tbl_count[i] = TOTAL_W'(1);
                n_words++;
                r.is_new = 1'b1;
            end
            r.slot_hit   = SLOT_W'(i);
            r.word_total = tbl_count[i];
        end
        tok_len = 0;
    endtask

    task automatic add_char(input logic [7:0] c, inout result_t r, output bit got);
        got = 0;
        if (tok_len < CHARS)
        begin
            tok[tok_len] = c;
            tok_len++;
        end
        if (tok_len >= CHARS)
            close_token(r, got);
    endtask

    task automatic predict_result(input logic [1:0] kind, input logic [7:0] c,
                                  input logic [4:0] s, input logic [4:0] p,
                                  output result_t r, output bit got);
        bit g;
        r   = '0;
        got = 0;
        g   = 0;
        case (req_kind_t'(kind))
            REQ_BYTE:
            begin
                if (closed)
                    open_text();
                // An apostrophe is kept only if an alphanumeric follows it.
                if (apos_wait)
                begin
                    apos_wait = 0;
                    if (alnum(c))
                        add_char(CH_APOS, r, got);
                    else
                        close_token(r, got);
                end
                if (alnum(c))
                begin
                    add_char(lower(c), r, g);
                    if (g)
                        got = 1;
                end
                else if (c == CH_APOS && alnum(last_byte))
                    apos_wait = 1;
                else
                begin
                    close_token(r, g);
                    if (g)
                        got = 1;
                end
                last_byte = c;
            end
            REQ_END:
            begin
                if (closed)
                    open_text();
                apos_wait = 0;
                close_token(r, g);
                r.text_done = 1'b1;
                got         = 1;
                tok_len     = 0;
                last_byte   = 8'd0;
                closed      = 1;
            end
            REQ_READ:
            begin
                if (s < n_words)
                begin
                    r.read_length = tbl_len[s];
                    r.read_total  = tbl_count[s];
                    if (p < tbl_len[s])
                        r.read_char = tbl_text[s][p];
                end
                got = 1;
            end
            default:
                got = 0;
        endcase
        if (got)
            r.distinct = DISTINCT_W'(n_words);
    endtask

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            $error("%s expected %0d got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        result_t w;
        bit      got;
        if (!rst_n)
        begin
            n_words   = 0;
            tok_len   = 0;
            last_byte = 8'd0;
            apos_wait = 0;
            closed    = 1;
            expected_q.delete();
            pending   = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_result(req.req_type, req.ch, req.slot, req.pos, r, got);
                if (got)
                    expected_q.push_back(r);
            end
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item arrived with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    w = expected_q.pop_front();
                    check_field("word_done", w.word_done, res.word_done);
                    check_field("slot_hit", w.slot_hit, res.slot_hit);
                    check_field("word_total", w.word_total, res.word_total);
                    check_field("is_new", w.is_new, res.is_new);
                    check_field("dropped", w.dropped, res.dropped);
                    check_field("text_done", w.text_done, res.text_done);
                    check_field("distinct", w.distinct, res.distinct);
                    check_field("read_char", w.read_char, res.read_char);
                    check_field("read_length", w.read_length, res.read_length);
                    check_field("read_total", w.read_total, res.read_total);
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

// ===== tb/sv/word_frequency_counter_tb.sv =====
// Testbench top: clock, reset, text stimulus, receiver stalls and the verdict.
module word_frequency_counter_tb import wfc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle;
    int   snk_idle;
    int   hold_cycles;
    int   items;

    wfc_req_if req_bus ();
    wfc_res_if res_bus ();

    word_frequency_counter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    word_frequency_counter_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_bus),
        .res        (res_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("word_frequency_counter verification failed");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_bus.ready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else
            res_bus.ready <= ($urandom_range(99) >= snk_idle);
    end

    task automatic send(input req_kind_t kind, input logic [7:0] c,
                        input logic [4:0] s, input logic [4:0] p);
        while ($urandom_range(99) < src_idle)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.ch       <= c;
        req_bus.slot     <= s;
        req_bus.pos      <= p;
        do
            @(posedge clk);
        while (!req_bus.ready);
        @(negedge clk);
        if (kind == REQ_BYTE || kind == REQ_END || kind == REQ_READ)
            items++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        send(REQ_BYTE, c, 5'($urandom_range(31)), 5'($urandom_range(30)));
    endtask

    task automatic send_str(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    task automatic send_read();
        send(REQ_READ, 8'($urandom_range(255)), 5'($urandom_range(31)),
             5'($urandom_range(30)));
    endtask

    // Vocabulary word k, with random case, sometimes an inner apostrophe and sometimes a final digit.
    task automatic emit_word(input int k);
        int         n;
        logic [7:0] c;
        n = 1 + k % 6;
        for (int i = 0; i < n; i++)
        begin
            c = 8'("a" + (k * 7 + i * 3) % 26);
            if (k % 5 == 0 && i == n - 1)
                c = 8'("0" + k % 10);
            else if ($urandom_range(3) == 0)
                c = c - 8'd32;
            send_byte(c);
            if (i == 0 && n > 1 && k % 4 == 0)
                send_byte(CH_APOS);
        end
    endtask

    task automatic emit_long_word();
        int n;
        n = $urandom_range(40, 29);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(1) ? "a" + $urandom_range(25) : "0" + $urandom_range(9)));
    endtask

    task automatic emit_text();
        int vocab;
        int nwords;
        vocab  = $urandom_range(1) ? $urandom_range(8, 2) : $urandom_range(70, 33);
        nwords = $urandom_range(45, 1);
        for (int w = 0; w < nwords; w++)
        begin
            if ($urandom_range(25) == 0)
                emit_long_word();
            else
                emit_word($urandom_range(vocab - 1));
            case ($urandom_range(9))
                0, 1, 2: send_byte(" ");
                3: send_byte($urandom_range(1) ? "," : ".");
                4: send_byte(8'($urandom_range(255)));
                5: send_str("''");
                6:
                begin
                    send_byte(8'h0a);
                    send_read();
                end
                7: send_str("' ");
                8: send(req_kind_t'(2'd3), 8'($urandom_range(255)), 5'($urandom_range(31)),
                        5'($urandom_range(31)));
                default: ;
            endcase
        end
        if ($urandom_range(1))
            send_byte(CH_APOS);
        send(REQ_END, 8'd0, 5'd0, 5'd0);
        for (int i = $urandom_range(3); i > 0; i--)
            send_read();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_BYTE;
        req_bus.ch       = 8'd0;
        req_bus.slot     = 5'd0;
        req_bus.pos      = 5'd0;
        res_bus.ready    = 1'b0;
        src_idle         = 0;
        snk_idle         = 0;
        hold_cycles      = 0;
        items            = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty text, folding, apostrophe rules, extreme bytes, word cap, reads, unknown request.
        send(REQ_END, 8'd0, 5'd0, 5'd0);
        send_str("'Don't x' a''Z9");
        send_byte(8'd0);
        send_byte(8'hff);
        send_str("abcdefghijklmnopqrstuvwxyz0123456789 ");
        send(REQ_READ, 8'd0, 5'd0, 5'd0);
        send(REQ_READ, 8'd0, 5'd31, 5'd30);
        send(REQ_READ, 8'd0, 5'd1, 5'd30);
        send(req_kind_t'(2'd3), 8'hff, 5'd31, 5'd31);
        send(REQ_END, 8'd0, 5'd0, 5'd0);
        send(REQ_END, 8'd0, 5'd0, 5'd0);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = (ph == 0) ? 33 : (ph == 1) ? 48 : 0;
            snk_idle = (ph == 0) ? 48 : (ph == 1) ? 33 : 0;
            if (ph == 2)
                hold_cycles = 400;
            while (items < 80 + (ph + 1) * 410)
                emit_text();
            // The sender pauses until every expected result has come.
            req_bus.valid <= 1'b0;
            do
                @(negedge clk);
            while (pending != 0);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("word_frequency_counter verification clean");
        else
            $display("word_frequency_counter verification failed");
        $finish;
    end
endmodule
